>>> sv/dfr_pkg.sv
// Shared types and constants of the length-prefixed packet deframer.
package dfr_pkg;

   // Header layout
   localparam int HELD_BYTES     = 6;
   localparam int HDR_IDX_W      = 3;
   localparam int LEN_BYTES      = 4;
   localparam int EXTRA_FLAG_BIT = 7;
   localparam int EXTRA_BYTES    = 4;
   localparam int ROUND_ADD      = 7;
   localparam int ROUND_BITS     = 3;

   // Datapath widths
   localparam int BYTE_W   = 8;
   localparam int SUM_W    = 34;
   localparam int ADDEND_W = 5;
   localparam int HB_W     = 4;
   localparam int PKT_W    = 31;
   localparam int TOTAL_W  = 31;

   // Configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 31;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_HEADER_BASE = 2'd0,
      CSR_MIN_PACKET  = 2'd1,
      CSR_MAX_PACKET  = 2'd2
   } dfr_csr_index_type;

   localparam logic [HB_W-1:0]  HEADER_BASE_RESET = 4'd6;
   localparam logic [PKT_W-1:0] MIN_PACKET_RESET  = 31'd8;
   localparam logic [PKT_W-1:0] MAX_PACKET_RESET  = 31'd10485760;

   typedef struct packed {
      logic [HB_W-1:0]  header_base;
      logic [PKT_W-1:0] min_packet;
      logic [PKT_W-1:0] max_packet;
   } dfr_cfg_type;

   // Front-end framing phase
   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_BODY   = 2'd1,
      PH_ERROR  = 2'd2
   } dfr_phase_type;

   // Work passed from front to back
   typedef enum logic [1:0] {
      CMD_BODY  = 2'd0,
      CMD_BURST = 2'd1,
      CMD_ERROR = 2'd2
   } dfr_cmd_kind_type;

   typedef struct packed {
      dfr_cmd_kind_type                      kind;
      logic [HELD_BYTES-1:0][BYTE_W-1:0]     data;
      logic                                  last;
   } dfr_cmd_type;

endpackage

>>> sv/dfr_if.sv
// Request and response channel interfaces of the deframer.
interface dfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       chunk_end;

   modport source (output valid, output data_byte, output chunk_end, input ready);
   modport sink (input valid, input data_byte, input chunk_end, output ready);
endinterface

interface dfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       packet_first;
   logic       packet_last;
   logic       run_last;
   logic       error_code;

   modport source (output valid, output out_byte, output packet_first,
                   output packet_last, output run_last, output error_code,
                   input ready);
   modport sink (input valid, input out_byte, input packet_first,
                 input packet_last, input run_last, input error_code,
                 output ready);
endinterface

>>> sv/dfr_queue.sv
// Small register FIFO of commands between the front and back ends.
module dfr_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  dfr_pkg::dfr_cmd_type push_cmd,
   input  logic                 pop,
   output dfr_pkg::dfr_cmd_type head_cmd,
   output logic                 full,
   output logic                 empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   dfr_pkg::dfr_cmd_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Advance pointers with wrap and track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed command
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> sv/dfr_front.sv
// Front end: takes request bytes, collects the header, checks the size, queues work.
module dfr_front #(
   parameter int LENGTH_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   dfr_req_if.sink              req_chan,
   input  dfr_pkg::dfr_cfg_type cfg,
   input  logic                 q_full,
   output logic                 push,
   output dfr_pkg::dfr_cmd_type push_cmd
);

   localparam int HELD = dfr_pkg::HELD_BYTES;
   localparam int BW   = dfr_pkg::BYTE_W;
   localparam int SW   = dfr_pkg::SUM_W;
   localparam int TW   = dfr_pkg::TOTAL_W;
   localparam int AW   = dfr_pkg::ADDEND_W;

   dfr_pkg::dfr_phase_type phase_ff, phase_in;
   logic [TW-1:0]          pos_ff, pos_in;
   logic [TW-1:0]          total_ff;
   logic [BW-1:0]          hdr_ff [HELD];

   logic                    accept;
   logic [dfr_pkg::HDR_IDX_W-1:0] hdr_idx;
   logic                    hdr_done;
   logic [TW-1:0]           pos_inc;
   logic                    body_last;
   logic [BW*dfr_pkg::LEN_BYTES-1:0] raw_len;
   logic [SW-1:0]           len_wide;
   logic [AW-1:0]           addend;
   logic [SW-1:0]           sum;
   logic [SW-1:0]           rounded;
   logic                    size_bad;
   logic [TW-1:0]           size_total;
   logic                    total_is_held;

   assign req_chan.ready = (phase_ff == dfr_pkg::PH_ERROR) || !q_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign hdr_idx        = pos_ff[dfr_pkg::HDR_IDX_W-1:0];
   assign hdr_done       = (hdr_idx == dfr_pkg::HDR_IDX_W'(HELD - 1));
   assign pos_inc        = pos_ff + 1'b1;
   assign body_last      = (pos_inc >= total_ff);

   // Size check on the final held byte: sign-extend, add header, round up to 8
   always_comb begin
      raw_len  = {hdr_ff[3], hdr_ff[2], hdr_ff[1], hdr_ff[0]};
      len_wide = {{(SW - LENGTH_BITS){raw_len[LENGTH_BITS-1]}},
                  raw_len[LENGTH_BITS-1:0]};
      addend   = AW'(cfg.header_base) + AW'(dfr_pkg::ROUND_ADD);
      if (req_chan.data_byte[dfr_pkg::EXTRA_FLAG_BIT]) begin
         addend = addend + AW'(dfr_pkg::EXTRA_BYTES);
      end
      sum      = len_wide + SW'(addend);
      rounded  = {sum[SW-1:dfr_pkg::ROUND_BITS], dfr_pkg::ROUND_BITS'(0)};
      size_bad = rounded[SW-1]
              || (rounded[SW-2:0] < (SW-1)'(HELD))
              || (rounded[SW-2:0] < (SW-1)'(cfg.min_packet))
              || (rounded[SW-2:0] > (SW-1)'(cfg.max_packet));
      size_total    = rounded[TW-1:0];
      total_is_held = (size_total == TW'(HELD));
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         dfr_pkg::PH_HEADER: begin
            if (accept && hdr_done) begin
               if (size_bad) begin
                  phase_in = dfr_pkg::PH_ERROR;
               end else if (!total_is_held) begin
                  phase_in = dfr_pkg::PH_BODY;
               end
            end
         end
         dfr_pkg::PH_BODY: begin
            if (accept && body_last) begin
               phase_in = dfr_pkg::PH_HEADER;
            end
         end
         dfr_pkg::PH_ERROR: phase_in = dfr_pkg::PH_ERROR;
         default:           phase_in = dfr_pkg::PH_ERROR;
      endcase
   end

   // Byte position within the packet
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         case (phase_ff)
            dfr_pkg::PH_HEADER: begin
               if (!hdr_done) begin
                  pos_in = pos_inc;
               end else if (!size_bad && !total_is_held) begin
                  pos_in = TW'(HELD);
               end else begin
                  pos_in = '0;
               end
            end
            dfr_pkg::PH_BODY: pos_in = body_last ? '0 : pos_inc;
            default:          pos_in = pos_ff;
         endcase
      end
   end

   // Queue work for the back end
   always_comb begin
      push          = 1'b0;
      push_cmd.kind = dfr_pkg::CMD_BODY;
      push_cmd.data = '0;
      push_cmd.last = 1'b0;
      case (phase_ff)
         dfr_pkg::PH_HEADER: begin
            if (accept && hdr_done) begin
               push          = 1'b1;
               push_cmd.kind = size_bad ? dfr_pkg::CMD_ERROR : dfr_pkg::CMD_BURST;
               for (int i = 0; i < HELD - 1; i++) begin
                  push_cmd.data[i] = hdr_ff[i];
               end
               push_cmd.data[HELD-1] = req_chan.data_byte;
               push_cmd.last         = total_is_held;
            end
         end
         dfr_pkg::PH_BODY: begin
            if (accept) begin
               push             = 1'b1;
               push_cmd.kind    = dfr_pkg::CMD_BODY;
               push_cmd.data[0] = req_chan.data_byte;
               push_cmd.last    = body_last;
            end
         end
         default: push = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dfr_pkg::PH_HEADER;
         pos_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
      end
   end

   // Hold header bytes and the accepted packet total
   always_ff @(posedge clock) begin
      if (accept && phase_ff == dfr_pkg::PH_HEADER) begin
         hdr_ff[hdr_idx] <= req_chan.data_byte;
         if (hdr_done && !size_bad) begin
            total_ff <= size_total;
         end
      end
   end

endmodule

>>> sv/dfr_back.sv
// Back end: pops queued work and drives the response register, one result per cycle while ready.
module dfr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  dfr_pkg::dfr_cmd_type head_cmd,
   input  logic                 q_empty,
   output logic                 pop,
   dfr_rsp_if.source            rsp_chan
);

   localparam int HELD = dfr_pkg::HELD_BYTES;
   localparam int IW   = dfr_pkg::HDR_IDX_W;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    out_byte_ff, out_byte_in;
   logic          first_ff, first_in;
   logic          last_ff, last_in;
   logic          run_last_ff, run_last_in;
   logic          error_ff, error_in;
   logic [IW-1:0] idx_ff, idx_in;

   logic load;
   logic burst_end;
   logic burst_more;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_byte     = out_byte_ff;
   assign rsp_chan.packet_first = first_ff;
   assign rsp_chan.packet_last  = last_ff;
   assign rsp_chan.run_last     = run_last_ff;
   assign rsp_chan.error_code   = error_ff;

   assign load       = !q_empty && (!rsp_valid_ff || rsp_chan.ready);
   assign burst_end  = (idx_ff == IW'(HELD - 1));
   assign burst_more = (head_cmd.kind == dfr_pkg::CMD_BURST) && !burst_end;
   assign pop        = load && !burst_more;

   // Advance the burst index and the response valid
   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         idx_in       = burst_more ? idx_ff + 1'b1 : '0;
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Build the next result from the head command
   always_comb begin
      out_byte_in = '0;
      first_in    = 1'b0;
      last_in     = 1'b0;
      run_last_in = 1'b1;
      error_in    = 1'b0;
      case (head_cmd.kind)
         dfr_pkg::CMD_BODY: begin
            out_byte_in = head_cmd.data[0];
            last_in     = head_cmd.last;
         end
         dfr_pkg::CMD_BURST: begin
            out_byte_in = head_cmd.data[idx_ff];
            first_in    = (idx_ff == '0);
            last_in     = head_cmd.last && burst_end;
            run_last_in = burst_end;
         end
         dfr_pkg::CMD_ERROR: error_in = 1'b1;
         default:            error_in = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   // Hold the response payload until taken
   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff <= out_byte_in;
         first_ff    <= first_in;
         last_ff     <= last_in;
         run_last_ff <= run_last_in;
         error_ff    <= error_in;
      end
   end

endmodule

>>> sv/length_prefixed_packet_deframer_core.sv
// Top level of the length-prefixed packet deframer: config registers and front/queue/back.
//
// Usage: the request channel takes one stream byte per cycle while ready
// (data_byte, chunk_end; chunk_end does not affect framing). The response
// channel gives packet bytes with first/last marks, a run_last mark on the
// final result of each request, or a single error result when a header size
// is out of range. Bytes 0..4 of a header give nothing; byte 5 releases all
// six held bytes as a run of six responses on consecutive cycles while the
// receiver is ready; later bytes pass one each. Each result passes through the
// queue and then the response register; at full rate a body byte also waits
// behind the rest of the header run.
// Throughput: one request per cycle with no gaps while the receiver is ready;
// a header run leaves up to six commands waiting, so QUEUE_DEPTH must be at
// least 7 to keep the request ready high (default 8). The user writes config
// (csr_wr_en, csr_index, csr_wdata) while the block is idle; the block does not
// enforce this. Reset clears the framing state, the queue and the response
// valid, and loads the register defaults. After a size error the block takes
// and drops every request until reset. When the receiver stalls, the response
// register holds, the queue fills, and then the request ready drops.
module length_prefixed_packet_deframer_core #(
   parameter int LENGTH_BITS = 32,
   parameter int QUEUE_DEPTH = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [dfr_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  logic [dfr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   dfr_req_if.sink                            req_chan,
   dfr_rsp_if.source                          rsp_chan
);

   dfr_pkg::dfr_cfg_type cfg_ff;
   dfr_pkg::dfr_cmd_type push_cmd;
   dfr_pkg::dfr_cmd_type head_cmd;
   logic                 push;
   logic                 pop;
   logic                 q_full;
   logic                 q_empty;

   // Configuration registers; unknown index is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_base <= dfr_pkg::HEADER_BASE_RESET;
         cfg_ff.min_packet  <= dfr_pkg::MIN_PACKET_RESET;
         cfg_ff.max_packet  <= dfr_pkg::MAX_PACKET_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            dfr_pkg::CSR_HEADER_BASE:
               cfg_ff.header_base <= csr_wdata[dfr_pkg::HB_W-1:0];
            dfr_pkg::CSR_MIN_PACKET:
               cfg_ff.min_packet <= csr_wdata[dfr_pkg::PKT_W-1:0];
            dfr_pkg::CSR_MAX_PACKET:
               cfg_ff.max_packet <= csr_wdata[dfr_pkg::PKT_W-1:0];
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   dfr_front #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cfg      (cfg_ff),
      .q_full   (q_full),
      .push     (push),
      .push_cmd (push_cmd)
   );

   dfr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   dfr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_cmd (head_cmd),
      .q_empty  (q_empty),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> tb/sv/length_prefixed_packet_deframer_core_tb.sv
// Self-checking testbench for the length-prefixed packet deframer core.
module length_prefixed_packet_deframer_core_tb;
   import dfr_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int STREAM_ITEMS  = 450;
   localparam int MAX_PRINTED   = 40;

   // Index past the last register; writes to it must be ignored
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [PKT_W-1:0]      PKT_CEIL   = 31'h7FFF_FFFF;

   typedef enum int {
      BAD_NEGATIVE,
      BAD_ZERO,
      BAD_OVER_MAX,
      BAD_UNDER_MIN
   } bad_size_kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       chunk_end;
   } stream_byte_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       packet_first;
      logic       packet_last;
      logic       run_last;
      logic       error_code;
   } framed_byte_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dfr_req_if req_bus ();
   dfr_rsp_if rsp_bus ();

   length_prefixed_packet_deframer_core dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   // Stream bytes waiting to be sent and responses waiting to arrive
   stream_byte_type stream_q[$];
   framed_byte_type framed_q[$];

   // Register copies
   logic [HB_W-1:0]  cfg_hb;
   logic [PKT_W-1:0] cfg_min;
   logic [PKT_W-1:0] cfg_max;

   // Framing state of the prediction
   dfr_phase_type fr_phase;
   logic [7:0]    fr_hdr [HELD_BYTES];
   int unsigned   fr_pos;
   longint        fr_total;

   int unsigned     mismatches;
   int unsigned     rsp_seen;
   int unsigned     queued_items;
   int unsigned     cycle_count;
   int unsigned     req_gap;
   int unsigned     ready_hold;
   bit              calm;
   stream_byte_type next_req;
   framed_byte_type got_rsp;
   framed_byte_type want_rsp;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic report(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("MISMATCH %s", msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report($sformatf("response %0d %s: got %0h, expected %0h",
                          rsp_seen, name, got, want));
   endtask

   // Advance the framing state by one stream byte and queue the responses it causes
   task automatic deframe_byte(input logic [7:0] b);
      framed_byte_type r;
      logic [31:0]     raw;
      longint          rounded;
      if (fr_phase == PH_ERROR) return;

      // Pass a body byte straight through
      if (fr_phase == PH_BODY) begin
         fr_pos++;
         r = '{out_byte: b, packet_first: 1'b0, packet_last: (fr_pos >= fr_total),
               run_last: 1'b1, error_code: 1'b0};
         framed_q = {framed_q, r};
         if (r.packet_last) begin
            fr_phase = PH_HEADER;
            fr_pos   = 0;
         end
         return;
      end

      // Hold header bytes until the sixth arrives
      if (fr_pos >= HELD_BYTES) fr_pos = 0;
      fr_hdr[fr_pos] = b;
      fr_pos++;
      if (fr_pos < HELD_BYTES) return;

      raw = {fr_hdr[3], fr_hdr[2], fr_hdr[1], fr_hdr[0]};
      rounded = $signed(raw);
      rounded = rounded + longint'(cfg_hb);
      if (fr_hdr[5][EXTRA_FLAG_BIT]) rounded = rounded + EXTRA_BYTES;
      rounded = (rounded + ROUND_ADD) & ~longint'(ROUND_ADD);

      // Latch the error on a size out of range
      if (rounded < HELD_BYTES || rounded < longint'(cfg_min) ||
          rounded > longint'(cfg_max)) begin
         r = '{out_byte: 8'd0, packet_first: 1'b0, packet_last: 1'b0,
               run_last: 1'b1, error_code: 1'b1};
         framed_q = {framed_q, r};
         fr_phase = PH_ERROR;
         return;
      end

      // Release the held bytes as one run
      fr_total = rounded;
      for (int i = 0; i < HELD_BYTES; i++) begin
         r = '{out_byte: fr_hdr[i], packet_first: (i == 0),
               packet_last: (i == HELD_BYTES - 1 && rounded == HELD_BYTES),
               run_last: (i == HELD_BYTES - 1), error_code: 1'b0};
         framed_q = {framed_q, r};
      end
      if (rounded == HELD_BYTES) begin
         fr_phase = PH_HEADER;
         fr_pos   = 0;
      end else begin
         fr_phase = PH_BODY;
         fr_pos   = HELD_BYTES;
      end
   endtask

   task automatic push_byte(input logic [7:0] b);
      stream_byte_type it;
      it.data_byte = b;
      it.chunk_end = ($urandom_range(0, 7) == 0);
      stream_q = {stream_q, it};
      queued_items++;
   endtask

   // Queue a header whose rounded size comes out to pkt_total, then body_len bytes
   task automatic queue_packet(input longint pkt_total, input int body_len);
      logic        extra;
      longint      len_wide;
      logic [31:0] len;
      extra    = $urandom_range(0, 1);
      len_wide = pkt_total - longint'(cfg_hb) - (extra ? EXTRA_BYTES : 0)
                 - longint'($urandom_range(0, ROUND_ADD));
      len      = len_wide[31:0];
      for (int i = 0; i < LEN_BYTES; i++) push_byte(len[8*i +: 8]);
      push_byte(8'($urandom));
      push_byte({extra, 7'($urandom)});
      for (int i = 0; i < body_len; i++) push_byte(8'($urandom));
   endtask

   // Pick a good rounded size inside the current min and max, mostly short
   function automatic longint pick_total();
      longint lo;
      longint hi;
      longint cap;
      lo  = (longint'(cfg_min) + 7) / 8;
      if (lo < 1) lo = 1;
      hi  = longint'(cfg_max) / 8;
      cap = ($urandom_range(0, 14) == 0) ? 40 : 10;
      if (hi > cap) hi = cap;
      return 8 * longint'($urandom_range(int'(lo), int'(hi)));
   endfunction

   task automatic queue_good_packets(input int count);
      longint t;
      @(negedge clock);
      for (int i = 0; i < count; i++) begin
         t = pick_total();
         queue_packet(t, int'(t) - HELD_BYTES);
      end
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_HEADER_BASE: cfg_hb  = val[HB_W-1:0];
         CSR_MIN_PACKET:  cfg_min = val[PKT_W-1:0];
         CSR_MAX_PACKET:  cfg_max = val[PKT_W-1:0];
         default: ;
      endcase
   endtask

   // Write all three registers; header_base carries junk in its upper bits
   task automatic write_config(input logic [HB_W-1:0] hb, input logic [PKT_W-1:0] lo,
                               input logic [PKT_W-1:0] hi);
      csr_write(CSR_HEADER_BASE, {27'($urandom), hb});
      csr_write(CSR_MIN_PACKET, lo);
      csr_write(CSR_MAX_PACKET, hi);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Wait until every byte is taken and every response is in, then let the pipe empty
   task automatic drain();
      do @(negedge clock);
      while (stream_q.size() != 0 || req_bus.valid || framed_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Drive stream bytes and predict on each accepted request
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) deframe_byte(req_bus.data_byte);
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (stream_q.size() > 0) begin
               next_req = stream_q.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.data_byte <= next_req.data_byte;
               req_bus.chunk_end <= next_req.chunk_end;
               req_gap = calm ? 0 : pick_gap();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Check each accepted response against the oldest prediction; stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         ready_hold = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got_rsp = '{rsp_bus.out_byte, rsp_bus.packet_first, rsp_bus.packet_last,
                        rsp_bus.run_last, rsp_bus.error_code};
            if (framed_q.size() == 0) begin
               report($sformatf("response %0d arrived with none expected (byte %0h)",
                                rsp_seen, got_rsp.out_byte));
            end else begin
               want_rsp = framed_q.pop_front();
               check_field("out_byte", got_rsp.out_byte, want_rsp.out_byte);
               check_field("packet_first", got_rsp.packet_first, want_rsp.packet_first);
               check_field("packet_last", got_rsp.packet_last, want_rsp.packet_last);
               check_field("run_last", got_rsp.run_last, want_rsp.run_last);
               check_field("error_code", got_rsp.error_code, want_rsp.error_code);
            end
            rsp_seen++;
         end
         if (ready_hold > 0) begin
            ready_hold--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            ready_hold = calm ? 0 : pick_gap();
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("length_prefixed_packet_deframer_core_tb: errors");
         $finish;
      end
   end

   initial begin
      bad_size_kind_type bad_kind;
      longint            bad_total;
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = CSR_HEADER_BASE;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = 8'd0;
      req_bus.chunk_end = 1'b0;
      rsp_bus.ready     = 1'b0;
      cfg_hb            = HEADER_BASE_RESET;
      cfg_min           = MIN_PACKET_RESET;
      cfg_max           = MAX_PACKET_RESET;
      fr_phase          = PH_HEADER;
      fr_pos            = 0;
      fr_total          = 0;
      mismatches        = 0;
      rsp_seen          = 0;
      queued_items      = 0;
      cycle_count       = 0;
      calm              = 1'b0;
      foreach (fr_hdr[i]) fr_hdr[i] = 8'd0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults: smallest packet, negative length with extra header, round-up
      @(negedge clock);
      push_byte(8'h02); push_byte(8'h00); push_byte(8'h00); push_byte(8'h00);
      push_byte(8'h00); push_byte(8'h00); push_byte(8'hFF); push_byte(8'h00);
      push_byte(8'hFE); push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFF);
      push_byte(8'hFF); push_byte(8'hFF); push_byte(8'h55); push_byte(8'hAA);
      push_byte(8'h01); push_byte(8'h00); push_byte(8'h00); push_byte(8'h00);
      push_byte(8'h7F); push_byte(8'h7F); push_byte(8'h00); push_byte(8'hFF);
      drain();

      // Widest window with no header base; a write to the unused index goes nowhere
      write_config(4'd0, 31'd0, PKT_CEIL);
      csr_write(CSR_UNUSED, 31'($urandom));
      @(posedge clock);
      csr_wr_en <= 1'b0;
      queue_good_packets(4);
      drain();

      // Largest header base, narrow window
      write_config(4'd15, 31'd16, 31'd64);
      queue_good_packets(4);
      drain();

      // Random settings, a few packets each
      while (queued_items < STREAM_ITEMS) begin
         calm = ($urandom_range(0, 3) == 0);
         cfg_min = 31'(8 * $urandom_range(0, 3));
         write_config(4'($urandom_range(0, 15)), cfg_min,
                      ($urandom_range(0, 3) == 0) ? PKT_CEIL
                         : cfg_min + 31'(8 * $urandom_range(4, 30)));
         queue_good_packets($urandom_range(3, 6));
         drain();
      end

      // Close with one bad size; everything after it is dropped
      calm     = 1'b0;
      bad_kind = bad_size_kind_type'($urandom_range(0, 3));
      case (bad_kind)
         BAD_NEGATIVE: begin
            write_config(4'($urandom_range(0, 15)), 31'd8, MAX_PACKET_RESET);
            bad_total = -8 * longint'($urandom_range(1, 100000));
         end
         BAD_ZERO: begin
            write_config(4'($urandom_range(0, 15)), 31'd0, MAX_PACKET_RESET);
            bad_total = 0;
         end
         BAD_OVER_MAX: begin
            write_config(4'($urandom_range(0, 15)), 31'd8,
                         31'(8 * $urandom_range(1, 10)));
            bad_total = longint'(cfg_max) + 8 * longint'($urandom_range(1, 4));
         end
         default: begin
            write_config(4'($urandom_range(0, 15)), PKT_CEIL, PKT_CEIL);
            bad_total = 8 * longint'($urandom_range(1, 10));
         end
      endcase
      @(negedge clock);
      queue_packet(bad_total, $urandom_range(10, 30));
      drain();
      repeat (20) @(negedge clock);

      if (mismatches == 0) begin
         $display("length_prefixed_packet_deframer_core_tb: clean");
      end else begin
         $display("length_prefixed_packet_deframer_core_tb: errors");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/dfr_pkg.sv
sv/dfr_if.sv
sv/dfr_queue.sv
sv/dfr_front.sv
sv/dfr_back.sv
sv/length_prefixed_packet_deframer_core.sv
tb/sv/length_prefixed_packet_deframer_core_tb.sv
